FILE: src/bfrd_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and helper functions for the battery frame receiver.
// Used by bms_frame_receiver_decoder; depends on nothing else.
package bfrd_pkg;

    // default store depth, number of header bytes held in flops, unit limit
    localparam int MAX_FRAME_BYTES_DEF = 57;
    localparam int HDR_BYTES = 5;
    localparam int MAX_UNITS = 16;

    // frame kinds
    localparam logic [1:0] KIND_SUMMARY = 2'd0;
    localparam logic [1:0] KIND_CELL    = 2'd1;
    localparam logic [1:0] KIND_ALARM   = 2'd2;

    // result status codes
    localparam logic [1:0] STAT_VALUE    = 2'd0;
    localparam logic [1:0] STAT_CRC_ERR  = 2'd1;
    localparam logic [1:0] STAT_UNIT_ERR = 2'd2;

    // value conversions
    localparam logic [1:0] OP_RAW     = 2'd0;
    localparam logic [1:0] OP_CURRENT = 2'd1;
    localparam logic [1:0] OP_TEMP    = 2'd2;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HDR,
        ST_CHECK,
        ST_RD,
        ST_WAIT_HI,
        ST_WAIT_LO,
        ST_EMIT
    } bfrd_state_t;

    typedef struct packed {
        logic       valid;
        logic [1:0] kind;
    } hdr_info_t;

    typedef struct packed {
        logic [5:0] addr;
        logic       single;
        logic [1:0] op;
        logic       last;
    } item_plan_t;

    // header recognition on the first three bytes
    function automatic hdr_info_t hdr_decode(input logic [7:0] b0, input logic [7:0] b1,
                                             input logic [7:0] b2);
        hdr_info_t h;
        h.valid = 1'b0;
        h.kind  = KIND_SUMMARY;
        if (b0 inside {[8'h01:8'h10]})
        begin
            if (b1 == 8'h04 && b2 == 8'h24)
            begin
                h.valid = 1'b1;
                h.kind  = KIND_SUMMARY;
            end
            else if (b1 == 8'h04 && b2 == 8'h34)
            begin
                h.valid = 1'b1;
                h.kind  = KIND_CELL;
            end
            else if (b1 == 8'h01 && b2 == 8'h12)
            begin
                h.valid = 1'b1;
                h.kind  = KIND_ALARM;
            end
        end
        return h;
    endfunction

    // total frame length per kind, crc included
    function automatic logic [6:0] frame_len_of(input logic [1:0] kind);
        logic [6:0] n;
        case (kind)
            KIND_SUMMARY: n = 7'd41;
            KIND_CELL:    n = 7'd57;
            default:      n = 7'd23;
        endcase
        return n;
    endfunction

    // one byte of modbus crc-16, reflected poly a001
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
        end
        return c;
    endfunction

    // where each quantity sits in the frame and how it is converted
    function automatic item_plan_t item_plan(input logic [1:0] kind, input logic [4:0] idx);
        item_plan_t p;
        p.addr   = 6'd3 + {idx, 1'b0};
        p.single = 1'b0;
        p.op     = OP_RAW;
        p.last   = 1'b0;
        case (kind)
            KIND_SUMMARY:
            begin
                if (idx == 5'd1)
                begin
                    p.op = OP_CURRENT;
                end
                else if (idx == 5'd6)
                begin
                    p.addr   = 6'd15;
                    p.single = 1'b1;
                end
                else if (idx == 5'd7)
                begin
                    p.addr   = 6'd16;
                    p.single = 1'b1;
                end
                else if (idx inside {5'd9, 5'd12, 5'd13})
                begin
                    p.op = OP_TEMP;
                end
                p.last = (idx == 5'd15);
            end
            KIND_CELL:
            begin
                if (idx >= 5'd16)
                begin
                    p.op = OP_TEMP;
                end
                if (idx == 5'd20)
                begin
                    p.addr = 6'd51;
                end
                else if (idx == 5'd21)
                begin
                    p.addr = 6'd53;
                end
                p.last = (idx == 5'd21);
            end
            default:
            begin
                p.addr   = 6'd3 + {1'b0, idx};
                p.single = 1'b1;
                p.last   = (idx == 5'd18);
            end
        endcase
        return p;
    endfunction

    // fixed-point conversion of one quantity
    function automatic logic signed [20:0] item_value(input logic [1:0] op,
                                                      input logic single,
                                                      input logic [7:0] hi,
                                                      input logic [7:0] lo);
        logic [20:0] w;
        logic [20:0] v;
        w = {5'd0, hi, lo};
        if (single)
        begin
            v = {13'd0, hi};
        end
        else
        begin
            case (op)
                OP_CURRENT: v = w - 21'd10000;
                OP_TEMP:    v = (w << 3) + (w << 1) - 21'd27315;
                default:    v = w;
            endcase
        end
        return signed'(v);
    endfunction

endpackage

FILE: src/bfrd_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// Stands alone; instanced by the frame receiver for its byte store.
module bfrd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 57
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: src/bms_frame_receiver_decoder.sv
`timescale 1ns / 1ps
// Battery unit frame receiver: header hunt, crc-16 check, field decode.
// Depends on bfrd_pkg and bfrd_ram.
//
// Usage
// - s_axis carries one received serial byte per word in tdata[7:0].
// - m_axis carries one decoded quantity per word; tlast marks the final word
//   of a frame. A bad crc or an out-of-range device gives a single word.
// - cfg_wen/cfg_wdata write the accepted device count (reset value 16).
//   Write it only while no frame is being decoded.
// Throughput
// - while collecting, a byte is taken every cycle; the byte that completes
//   a valid five-byte header is followed by a pass that folds the header into
//   the crc, one byte per cycle, and no bytes are taken during it.
// - after the last byte: a check state, then per quantity a read, a high
//   byte wait, a low byte wait (16-bit ones only) and an emit, reading
//   through the one read port of the byte store; no bytes are taken then.
// Reset
// - the fill count and sequencer clear; the byte store keeps no reset and
//   needs no clearing pass, since only written bytes are ever used.
// Stall
// - a held output word stalls the decoder at its next result; input is
//   taken again once the last word of a frame is in the output register.
module bms_frame_receiver_decoder
#(
    parameter int MAX_FRAME_BYTES = bfrd_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // tdata: rx_byte[7:0]
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,
    // tdata: unit[3:0], item_index[8:4], item_value[29:9], zero[31:30]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,
    // tuser: frame_kind[1:0], status[3:2]
    output logic [3:0]  m_axis_tuser,
    output logic        m_axis_tlast,
    input  logic        cfg_wen,
    input  logic [4:0]  cfg_wdata
);

    import bfrd_pkg::*;

    localparam int AW    = $clog2(MAX_FRAME_BYTES);
    localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 1);

    bfrd_state_t state_reg, state_next;

    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [7:0]         w_reg [HDR_BYTES];
    logic [7:0]         w_next [HDR_BYTES];
    logic [1:0]         kind_reg, kind_next;
    logic [15:0]        crc_reg, crc_next;
    logic [15:0]        rxcrc_reg, rxcrc_next;
    logic [2:0]         hk_reg, hk_next;
    logic [4:0]         item_reg, item_next;
    logic [AW-1:0]      ra_reg, ra_next;
    logic [7:0]         hi_reg, hi_next;
    logic [7:0]         lo_reg, lo_next;
    logic [4:0]         dev_cnt_reg;

    logic               ov_reg, ov_next;
    logic [3:0]         o_unit_reg, o_unit_next;
    logic [1:0]         o_kind_reg, o_kind_next;
    logic [4:0]         o_idx_reg, o_idx_next;
    logic signed [20:0] o_val_reg, o_val_next;
    logic [1:0]         o_stat_reg, o_stat_next;
    logic               o_last_reg, o_last_next;

    logic               in_acc;
    hdr_info_t          hk;
    logic               hdr_ok;
    logic [CNT_W-1:0]   len_m1, len_m2;
    logic               slot_free;
    logic [3:0]         unit;
    logic [4:0]         lim;
    logic               err_crc, err_unit;
    item_plan_t         plan;
    logic [7:0]         src_byte;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr, ram_raddr;
    logic [7:0]         ram_rdata;

    // byte store
    bfrd_ram #(
        .WIDTH (8),
        .DEPTH (MAX_FRAME_BYTES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (s_axis_tdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // shared decode of the held state
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign hk            = hdr_decode(w_reg[0], w_reg[1], w_reg[2]);
    assign hdr_ok        = hk.valid && (int'(frame_len_of(hk.kind)) <= MAX_FRAME_BYTES);
    assign len_m1        = CNT_W'(frame_len_of(kind_reg) - 7'd1);
    assign len_m2        = CNT_W'(frame_len_of(kind_reg) - 7'd2);
    assign slot_free     = !ov_reg || m_axis_tready;
    assign unit          = 4'(w_reg[0] - 8'd1);
    assign lim           = (dev_cnt_reg < 5'(MAX_UNITS)) ? dev_cnt_reg : 5'(MAX_UNITS);
    assign err_crc       = (rxcrc_reg != crc_reg);
    assign err_unit      = ({1'b0, unit} >= lim);
    assign plan          = item_plan(kind_reg, item_reg);
    assign src_byte      = (int'(ra_reg) < HDR_BYTES) ? w_reg[ra_reg[2:0]] : ram_rdata;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (int'(cnt_reg) == HDR_BYTES - 1)
                    begin
                        if (hdr_ok)
                        begin
                            state_next = ST_HDR;
                        end
                    end
                    else if (int'(cnt_reg) >= HDR_BYTES && cnt_reg == len_m1)
                    begin
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_HDR:
            begin
                if (int'(hk_reg) == HDR_BYTES - 1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_CHECK:
            begin
                if (err_crc || err_unit)
                begin
                    if (slot_free)
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    state_next = ST_RD;
                end
            end
            ST_RD:
            begin
                state_next = ST_WAIT_HI;
            end
            ST_WAIT_HI:
            begin
                state_next = plan.single ? ST_EMIT : ST_WAIT_LO;
            end
            ST_WAIT_LO:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    state_next = plan.last ? ST_IDLE : ST_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and output register next values
    always_comb
    begin
        cnt_next    = cnt_reg;
        w_next      = w_reg;
        kind_next   = kind_reg;
        crc_next    = crc_reg;
        rxcrc_next  = rxcrc_reg;
        hk_next     = hk_reg;
        item_next   = item_reg;
        ra_next     = ra_reg;
        hi_next     = hi_reg;
        lo_next     = lo_reg;
        ram_we      = 1'b0;
        ram_waddr   = cnt_reg[AW-1:0];
        ram_raddr   = '0;
        ov_next     = ov_reg && !m_axis_tready;
        o_unit_next = o_unit_reg;
        o_kind_next = o_kind_reg;
        o_idx_next  = o_idx_reg;
        o_val_next  = o_val_reg;
        o_stat_next = o_stat_reg;
        o_last_next = o_last_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (int'(cnt_reg) < HDR_BYTES - 1)
                    begin
                        // filling the header window
                        w_next[cnt_reg[2:0]] = s_axis_tdata;
                        cnt_next = cnt_reg + 1'b1;
                    end
                    else if (int'(cnt_reg) == HDR_BYTES - 1)
                    begin
                        if (hdr_ok)
                        begin
                            w_next[HDR_BYTES-1] = s_axis_tdata;
                            cnt_next  = cnt_reg + 1'b1;
                            kind_next = hk.kind;
                            crc_next  = 16'hFFFF;
                            hk_next   = '0;
                        end
                        else
                        begin
                            // slide the window by one byte
                            for (int j = 0; j < HDR_BYTES - 2; j++)
                            begin
                                w_next[j] = w_reg[j+1];
                            end
                            w_next[HDR_BYTES-2] = s_axis_tdata;
                        end
                    end
                    else
                    begin
                        // frame body goes to the store
                        ram_we = 1'b1;
                        if (cnt_reg < len_m2)
                        begin
                            crc_next = crc_byte(crc_reg, s_axis_tdata);
                            cnt_next = cnt_reg + 1'b1;
                        end
                        else if (cnt_reg == len_m2)
                        begin
                            rxcrc_next[7:0] = s_axis_tdata;
                            cnt_next = cnt_reg + 1'b1;
                        end
                        else
                        begin
                            rxcrc_next[15:8] = s_axis_tdata;
                            cnt_next = '0;
                        end
                    end
                end
            end
            ST_HDR:
            begin
                // fold the held header bytes into the crc
                crc_next = crc_byte(crc_reg, w_reg[hk_reg]);
                hk_next  = hk_reg + 1'b1;
            end
            ST_CHECK:
            begin
                item_next = '0;
                if ((err_crc || err_unit) && slot_free)
                begin
                    ov_next     = 1'b1;
                    o_unit_next = unit;
                    o_kind_next = kind_reg;
                    o_idx_next  = '0;
                    o_val_next  = '0;
                    o_stat_next = err_crc ? STAT_CRC_ERR : STAT_UNIT_ERR;
                    o_last_next = 1'b1;
                end
            end
            ST_RD:
            begin
                ram_raddr = AW'(plan.addr);
                ra_next   = AW'(plan.addr);
            end
            ST_WAIT_HI:
            begin
                hi_next   = src_byte;
                ram_raddr = AW'(plan.addr + 6'd1);
                ra_next   = AW'(plan.addr + 6'd1);
            end
            ST_WAIT_LO:
            begin
                lo_next = src_byte;
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    ov_next     = 1'b1;
                    o_unit_next = unit;
                    o_kind_next = kind_reg;
                    o_idx_next  = item_reg;
                    o_val_next  = item_value(plan.op, plan.single, hi_reg, lo_reg);
                    o_stat_next = STAT_VALUE;
                    o_last_next = plan.last;
                    item_next   = item_reg + 1'b1;
                end
            end
            default:
            begin
                ram_raddr = '0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            ov_reg      <= 1'b0;
            dev_cnt_reg <= 5'(MAX_UNITS);
            hk_reg      <= '0;
            item_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ov_reg    <= ov_next;
            hk_reg    <= hk_next;
            item_reg  <= item_next;
            if (cfg_wen)
            begin
                dev_cnt_reg <= cfg_wdata;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        w_reg      <= w_next;
        kind_reg   <= kind_next;
        crc_reg    <= crc_next;
        rxcrc_reg  <= rxcrc_next;
        ra_reg     <= ra_next;
        hi_reg     <= hi_next;
        lo_reg     <= lo_next;
        o_unit_reg <= o_unit_next;
        o_kind_reg <= o_kind_next;
        o_idx_reg  <= o_idx_next;
        o_val_reg  <= o_val_next;
        o_stat_reg <= o_stat_next;
        o_last_reg <= o_last_next;
    end

    // output word
    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = {2'b00, o_val_reg, o_idx_reg, o_unit_reg};
    assign m_axis_tuser  = {o_stat_reg, o_kind_reg};
    assign m_axis_tlast  = o_last_reg;

    // checks
    a_hdr_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_HDR |-> int'(cnt_reg) == HDR_BYTES)
        else $error("header fold outside a confirmed header");

    a_check_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CHECK |-> cnt_reg == '0)
        else $error("fill count not cleared at frame end");

    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[3:2] != STAT_VALUE |-> m_axis_tlast)
        else $error("error word not marked last");

    a_item_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT |-> item_reg <= 5'd21)
        else $error("item index out of range");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> int'(cnt_reg) < MAX_FRAME_BYTES)
        else $error("fill count past store depth");

endmodule
